// File: hw/rtl/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// RGBE scanline decoder package
// Shared constants, the classified byte item and the decoder state codes.
// ----------------------------------------------------------------------------
package rgbe_pkg;

  localparam logic [15:0] MIN_NEW_WIDTH = 16'd8;
  localparam logic [15:0] MAX_NEW_WIDTH = 16'h7fff;
  localparam logic [7:0]  RUN_FLAG      = 8'd128;
  localparam logic [6:0]  LEN_MASK      = 7'd127;
  localparam logic [7:0]  HDR_BYTE      = 8'd2;

  localparam logic [1:0]  QUEUE_FULL    = 2'd2;

  localparam logic [2:0]  TGT_RED       = 3'd0;
  localparam logic [2:0]  TGT_GREEN     = 3'd1;
  localparam logic [2:0]  TGT_BLUE      = 3'd2;
  localparam logic [2:0]  TGT_EXP       = 3'd3;
  localparam logic [2:0]  TGT_PIXEL     = 3'd4;

  localparam logic [1:0]  PLANE_EXP     = 2'd3;
  localparam logic [1:0]  SHIFT_MAX     = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       is_zero;
    logic       is_one;
    logic       is_two;
    logic       is_run;
  } item_t;

  typedef enum logic [7:0] {
    ST_LINE_START = 8'b0000_0001,
    ST_HDR_G      = 8'b0000_0010,
    ST_HDR_B      = 8'b0000_0100,
    ST_HDR_E      = 8'b0000_1000,
    ST_OLD_PIX    = 8'b0001_0000,
    ST_NEW_CODE   = 8'b0010_0000,
    ST_NEW_RUNVAL = 8'b0100_0000,
    ST_NEW_LIT    = 8'b1000_0000
  } state_t;

endpackage

// File: hw/rtl/rgbe_front.sv
// ----------------------------------------------------------------------------
// RGBE decoder front end
// Classifies each accepted byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module rgbe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  output logic           q_valid,
  output rgbe_pkg::item_t q_item,
  input  logic           q_take
);
  import rgbe_pkg::*;

  item_t      slots [2];
  item_t      cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_comb begin
    cls.data    = data_byte;
    cls.is_zero = (data_byte == 8'd0);
    cls.is_one  = (data_byte == 8'd1);
    cls.is_two  = (data_byte == HDR_BYTE);
    cls.is_run  = (data_byte > RUN_FLAG);
  end

  assign in_stall = (count == QUEUE_FULL);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// File: hw/rtl/rgbe_back.sv
// ----------------------------------------------------------------------------
// RGBE decoder back end
// Runs the scanline state machine on queued bytes and registers descriptors.
// ----------------------------------------------------------------------------
module rgbe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  input  logic            q_valid,
  input  rgbe_pkg::item_t q_item,
  output logic            q_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     start_column,
  output logic [15:0]     run_count,
  output logic [2:0]      target,
  output logic [7:0]      red_value,
  output logic [7:0]      green_value,
  output logic [7:0]      blue_value,
  output logic [7:0]      exponent_value,
  output logic            line_end,
  output logic            overrun
);
  import rgbe_pkg::*;

  state_t      state, state_next;
  logic [15:0] line_width;
  logic [15:0] column, column_next;
  logic [1:0]  plane, plane_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [7:0]  literal_left, literal_left_next;
  logic [1:0]  shift_idx, shift_idx_next;
  logic [31:0] last_pixel, last_pixel_next;
  logic [7:0]  pend_r, pend_r_next, pend_g, pend_g_next, pend_b, pend_b_next;
  logic        r_one, r_one_next, g_one, g_one_next, b_one, b_one_next;
  logic        g_two, g_two_next;

  logic [15:0] width_eff;
  logic        new_ok;
  logic [15:0] rem;
  logic [7:0]  d;

  logic        is_rep;
  logic [31:0] want;
  logic        rep_clip;
  logic        rep_end;
  logic [15:0] old_cnt;
  logic        old_emit;
  logic        old_end;
  logic [31:0] old_px;

  logic        is_runval;
  logic [7:0]  lit_dec;
  logic [7:0]  lit_after;
  logic [15:0] pw_raw;
  logic        pw_clip;
  logic        pw_end;
  logic [15:0] pw_cnt;
  logic        pw_more;

  logic        do_old;
  logic        do_pw;
  logic        emit;
  logic [15:0] e_cnt;
  logic [2:0]  e_tgt;
  logic [31:0] e_px;
  logic        e_end;
  logic        e_ovr;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign q_take    = q_valid && out_free && !cfg_valid;
  assign d         = q_item.data;

  assign width_eff = (line_width == 16'd0) ? 16'd1 : line_width;
  assign new_ok    = (width_eff >= MIN_NEW_WIDTH) && (width_eff <= MAX_NEW_WIDTH);
  assign rem       = width_eff - column;

  assign is_rep   = r_one && g_one && b_one;
  assign want     = {24'd0, d} << {shift_idx, 3'b000};
  assign rep_clip = want > {16'd0, rem};
  assign rep_end  = want >= {16'd0, rem};
  assign old_cnt  = is_rep ? (rep_clip ? rem : want[15:0]) : 16'd1;
  assign old_emit = !(is_rep && q_item.is_zero);
  assign old_end  = is_rep ? rep_end : (rem == 16'd1);
  assign old_px   = is_rep ? last_pixel : {d, pend_b, pend_g, pend_r};

  assign is_runval = (state == ST_NEW_RUNVAL);
  assign lit_dec   = literal_left - 8'd1;
  assign lit_after = is_runval ? 8'd0 : lit_dec;
  assign pw_raw    = is_runval ? {8'd0, literal_left} : 16'd1;
  assign pw_clip   = pw_raw > rem;
  assign pw_end    = pw_raw >= rem;
  assign pw_cnt    = pw_clip ? rem : pw_raw;
  assign pw_more   = !is_runval && (lit_dec != 8'd0);

  always_comb begin
    state_next        = state;
    column_next       = column;
    plane_next        = plane;
    byte_slot_next    = byte_slot;
    literal_left_next = literal_left;
    shift_idx_next    = shift_idx;
    last_pixel_next   = last_pixel;
    pend_r_next       = pend_r;
    pend_g_next       = pend_g;
    pend_b_next       = pend_b;
    r_one_next        = r_one;
    g_one_next        = g_one;
    b_one_next        = b_one;
    g_two_next        = g_two;
    do_old            = 1'b0;
    do_pw             = 1'b0;
    emit              = 1'b0;
    e_cnt             = 16'd1;
    e_tgt             = TGT_PIXEL;
    e_px              = 32'd0;
    e_end             = 1'b0;
    e_ovr             = 1'b0;

    if (cfg_valid) begin
      state_next        = ST_LINE_START;
      column_next       = 16'd0;
      plane_next        = 2'd0;
      byte_slot_next    = 2'd0;
      literal_left_next = 8'd0;
      shift_idx_next    = 2'd0;
    end else if (q_take) begin
      case (state)
        ST_LINE_START: begin
          column_next    = 16'd0;
          plane_next     = 2'd0;
          shift_idx_next = 2'd0;
          pend_r_next    = d;
          r_one_next     = q_item.is_one;
          if (new_ok && q_item.is_two) begin
            state_next = ST_HDR_G;
          end else begin
            byte_slot_next = 2'd1;
            state_next     = ST_OLD_PIX;
          end
        end
        ST_HDR_G: begin
          pend_g_next = d;
          g_one_next  = q_item.is_one;
          g_two_next  = q_item.is_two;
          state_next  = ST_HDR_B;
        end
        ST_HDR_B: begin
          pend_b_next = d;
          b_one_next  = q_item.is_one;
          state_next  = ST_HDR_E;
        end
        ST_HDR_E: begin
          if (!g_two || pend_b[7]) begin
            do_old = 1'b1;
          end else begin
            plane_next  = 2'd0;
            column_next = 16'd0;
            state_next  = ST_NEW_CODE;
          end
        end
        ST_OLD_PIX: begin
          byte_slot_next = byte_slot + 2'd1;
          case (byte_slot)
            2'd0: begin
              pend_r_next = d;
              r_one_next  = q_item.is_one;
            end
            2'd1: begin
              pend_g_next = d;
              g_one_next  = q_item.is_one;
            end
            2'd2: begin
              pend_b_next = d;
              b_one_next  = q_item.is_one;
            end
            default: do_old = 1'b1;
          endcase
        end
        ST_NEW_CODE: begin
          if (q_item.is_run) begin
            literal_left_next = {1'b0, d[6:0] & LEN_MASK};
            state_next        = ST_NEW_RUNVAL;
          end else if (!q_item.is_zero) begin
            literal_left_next = d;
            state_next        = ST_NEW_LIT;
          end
        end
        ST_NEW_RUNVAL: do_pw = 1'b1;
        ST_NEW_LIT:    do_pw = 1'b1;
        default: begin
          state_next        = ST_LINE_START;
          column_next       = 16'd0;
          plane_next        = 2'd0;
          byte_slot_next    = 2'd0;
          literal_left_next = 8'd0;
          shift_idx_next    = 2'd0;
        end
      endcase

      if (do_old) begin
        byte_slot_next = 2'd0;
        state_next     = ST_OLD_PIX;
        emit           = old_emit;
        e_cnt          = old_cnt;
        e_tgt          = TGT_PIXEL;
        e_px           = old_px;
        e_end          = old_end;
        e_ovr          = is_rep && rep_clip;
        if (is_rep) begin
          shift_idx_next = (shift_idx == SHIFT_MAX) ? SHIFT_MAX : shift_idx + 2'd1;
        end else begin
          last_pixel_next = old_px;
          shift_idx_next  = 2'd0;
        end
        if (old_emit) begin
          column_next = column + old_cnt;
          if (old_end) begin
            state_next        = ST_LINE_START;
            column_next       = 16'd0;
            plane_next        = 2'd0;
            literal_left_next = 8'd0;
            shift_idx_next    = 2'd0;
          end
        end
      end

      if (do_pw) begin
        emit        = 1'b1;
        e_cnt       = pw_cnt;
        e_tgt       = {1'b0, plane};
        e_px        = {24'd0, d};
        column_next = column + pw_cnt;
        if (pw_end) begin
          last_pixel_next[{plane, 3'b000} +: 8] = d;
          literal_left_next = 8'd0;
          e_ovr             = pw_more || pw_clip;
          if (plane == PLANE_EXP) begin
            e_end          = 1'b1;
            state_next     = ST_LINE_START;
            column_next    = 16'd0;
            plane_next     = 2'd0;
            byte_slot_next = 2'd0;
            shift_idx_next = 2'd0;
          end else begin
            plane_next  = plane + 2'd1;
            column_next = 16'd0;
            state_next  = ST_NEW_CODE;
          end
        end else begin
          literal_left_next = lit_after;
          state_next        = (lit_after != 8'd0) ? ST_NEW_LIT : ST_NEW_CODE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LINE_START;
      line_width   <= 16'd1;
      column       <= 16'd0;
      plane        <= 2'd0;
      byte_slot    <= 2'd0;
      literal_left <= 8'd0;
      shift_idx    <= 2'd0;
      last_pixel   <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      column       <= column_next;
      plane        <= plane_next;
      byte_slot    <= byte_slot_next;
      literal_left <= literal_left_next;
      shift_idx    <= shift_idx_next;
      last_pixel   <= last_pixel_next;
      if (cfg_valid && cfg_ready) begin
        line_width <= cfg_data;
      end
      if (q_take) begin
        out_valid <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_r_next;
    pend_g <= pend_g_next;
    pend_b <= pend_b_next;
    r_one  <= r_one_next;
    g_one  <= g_one_next;
    b_one  <= b_one_next;
    g_two  <= g_two_next;
    if (q_take && emit) begin
      start_column   <= column;
      run_count      <= e_cnt;
      target         <= e_tgt;
      red_value      <= e_px[7:0];
      green_value    <= e_px[15:8];
      blue_value     <= e_px[23:16];
      exponent_value <= e_px[31:24];
      line_end       <= e_end;
      overrun        <= e_ovr;
    end
  end

`ifndef SYNTH
  a_column_in_line: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LINE_START) |-> (column < width_eff))
    else $error("column outside scanline");

  a_literal_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NEW_LIT || state == ST_NEW_RUNVAL) |-> (literal_left != 8'd0))
    else $error("empty literal or run count in flight");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_count != 16'd0))
    else $error("descriptor with zero count");

  a_pixel_clip_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overrun && target == TGT_PIXEL) |-> line_end)
    else $error("clipped repeat did not end the line");
`endif

endmodule

// File: hw/rtl/rgbe_scanline_rle_decoder.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder
// Decodes a Radiance HDR pixel byte stream into run descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one compressed byte per item.
//   Output channel out_valid/out_stall carries one run descriptor per item;
//   bytes that only collect header or pixel data give no descriptor.
//   cfg_valid/cfg_ready writes line_width (zero acts as one) and returns the
//   decoder to line start; write it only while the block is idle.
//   Throughput: one byte per cycle while out_stall does not hold the output register and cfg_valid is low.
//   Path: each byte waits in the two-entry byte queue, then the back end
//   decodes it and registers the descriptor in the output register; a
//   stalled receiver or a cfg_valid write can hold the byte in the queue.
//   in_stall rises only when the queue is full, so a stalled receiver holds
//   the output register and the queue takes at most two more items.
//   Reset: line start, column zero, line_width one, last pixel zero.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] start_column,
  output logic [15:0] run_count,
  output logic [2:0]  target,
  output logic [7:0]  red_value,
  output logic [7:0]  green_value,
  output logic [7:0]  blue_value,
  output logic [7:0]  exponent_value,
  output logic        line_end,
  output logic        overrun
);
  import rgbe_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_take;

  rgbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  rgbe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .start_column   (start_column),
    .run_count      (run_count),
    .target         (target),
    .red_value      (red_value),
    .green_value    (green_value),
    .blue_value     (blue_value),
    .exponent_value (exponent_value),
    .line_end       (line_end),
    .overrun        (overrun)
  );

endmodule

// File: tb/rgbe_scanline_rle_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder testbench
// Feeds old-format, new-format and malformed scanlines at a range of line
// widths. A scoreboard decodes each accepted byte in parallel and compares
// every run descriptor the block gives against the oldest one it expects.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder_test;
  import rgbe_pkg::*;

  typedef struct packed {
    logic [15:0] start_col;
    logic [15:0] count;
    logic [2:0]  tgt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  expo;
    logic        last;
    logic        clip;
  } descriptor_t;

  class descriptor_scoreboard;
    descriptor_t expected_runs[$];
    int unsigned errors;
    int unsigned seen;
    logic [15:0] width_reg;
    state_t      st;
    int unsigned col;
    logic [1:0]  plane_idx;
    logic [23:0] pend;
    int unsigned slot;
    int unsigned lit_left;
    int unsigned shift;
    logic [31:0] last_px;

    function new();
      width_reg = 16'd1;
      last_px = '0;
      errors = 0;
      seen = 0;
      line_restart();
    endfunction

    function void line_restart();
      st = ST_LINE_START;
      col = 0;
      plane_idx = '0;
      pend = '0;
      slot = 0;
      lit_left = 0;
      shift = 0;
    endfunction

    function void set_width(logic [15:0] v);
      width_reg = v;
      line_restart();
    endfunction

    function int unsigned span();
      return (width_reg == 16'd0) ? 1 : width_reg;
    endfunction

    function void expect_run(int unsigned start, int unsigned cnt, logic [2:0] tgt,
                             logic [31:0] px, bit last, bit clip);
      descriptor_t r;
      r.start_col = start[15:0];
      r.count = cnt[15:0];
      r.tgt = tgt;
      r.red = px[7:0];
      r.green = px[15:8];
      r.blue = px[23:16];
      r.expo = px[31:24];
      r.last = last;
      r.clip = clip;
      expected_runs.push_back(r);
    endfunction

    function void finish_pixel(logic [7:0] e);
      int unsigned w;
      int unsigned rem;
      int unsigned start;
      int unsigned cnt;
      longint unsigned want;
      logic [23:0] rgb;
      logic [31:0] px;
      bit clip;
      w = span();
      rem = (col < w) ? w - col : 1;
      start = col;
      clip = 1'b0;
      rgb = pend;
      pend = '0;
      slot = 0;
      if (rgb == 24'h010101) begin
        want = e;
        want = want << shift;
        shift = (shift >= 24) ? 24 : shift + 8;
        if (want == 0) return;
        if (want > rem) begin
          cnt = rem;
          clip = 1'b1;
        end else begin
          cnt = 32'(want);
        end
        px = last_px;
      end else begin
        cnt = 1;
        px = {e, rgb};
        last_px = px;
        shift = 0;
      end
      col = start + cnt;
      expect_run(start, cnt, TGT_PIXEL, px, col >= w, clip);
      if (col >= w) line_restart();
      else st = ST_OLD_PIX;
    endfunction

    function void fill_plane(int unsigned cnt, logic [7:0] v, bit more);
      int unsigned w;
      int unsigned rem;
      int unsigned start;
      logic [1:0] p;
      bit clip;
      bit last;
      w = span();
      rem = (col < w) ? w - col : 1;
      start = col;
      p = plane_idx;
      clip = more;
      last = 1'b0;
      if (cnt > rem) begin
        cnt = rem;
        clip = 1'b1;
      end
      col = start + cnt;
      if (col >= w) begin
        last_px[8*p +: 8] = v;
        lit_left = 0;
        if (p == PLANE_EXP) begin
          last = 1'b1;
        end else begin
          plane_idx = p + 2'd1;
          col = 0;
          st = ST_NEW_CODE;
        end
      end else begin
        clip = 1'b0;
        st = (lit_left != 0) ? ST_NEW_LIT : ST_NEW_CODE;
      end
      expect_run(start, cnt, {1'b0, p}, {24'h0, v}, last, clip);
      if (last) line_restart();
    endfunction

    function void note_byte(logic [7:0] d);
      int unsigned w;
      int unsigned run_len;
      w = span();
      case (st)
        ST_LINE_START: begin
          col = 0;
          plane_idx = '0;
          shift = 0;
          pend = {16'h0, d};
          if (w >= MIN_NEW_WIDTH && w <= MAX_NEW_WIDTH && d == HDR_BYTE) begin
            st = ST_HDR_G;
          end else begin
            slot = 1;
            st = ST_OLD_PIX;
          end
        end
        ST_HDR_G: begin
          pend[15:8] = d;
          st = ST_HDR_B;
        end
        ST_HDR_B: begin
          pend[23:16] = d;
          st = ST_HDR_E;
        end
        ST_HDR_E: begin
          if (pend[15:8] != HDR_BYTE || pend[23]) begin
            finish_pixel(d);
          end else begin
            pend = '0;
            plane_idx = '0;
            col = 0;
            st = ST_NEW_CODE;
          end
        end
        ST_OLD_PIX: begin
          if (slot < 3) begin
            pend[8*slot +: 8] = d;
            slot++;
          end else begin
            finish_pixel(d);
          end
        end
        ST_NEW_CODE: begin
          if (d > RUN_FLAG) begin
            lit_left = d & LEN_MASK;
            st = ST_NEW_RUNVAL;
          end else if (d != 8'd0) begin
            lit_left = d;
            st = ST_NEW_LIT;
          end
        end
        ST_NEW_RUNVAL: begin
          run_len = lit_left;
          lit_left = 0;
          fill_plane(run_len, d, 1'b0);
        end
        ST_NEW_LIT: begin
          lit_left = (lit_left > 0) ? lit_left - 1 : 0;
          fill_plane(1, d, lit_left != 0);
        end
        default: line_restart();
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("descriptor %0d %s got %0h expected %0h", seen, name, got, want));
    endtask

    task check_descriptor(descriptor_t got);
      descriptor_t want;
      seen++;
      if (expected_runs.size() == 0) begin
        report($sformatf("descriptor %0d at column %0d with nothing expected",
                         seen, got.start_col));
        return;
      end
      want = expected_runs.pop_front();
      compare("start_column", got.start_col, want.start_col);
      compare("run_count", got.count, want.count);
      compare("target", {13'h0, got.tgt}, {13'h0, want.tgt});
      compare("red_value", {8'h0, got.red}, {8'h0, want.red});
      compare("green_value", {8'h0, got.green}, {8'h0, want.green});
      compare("blue_value", {8'h0, got.blue}, {8'h0, want.blue});
      compare("exponent_value", {8'h0, got.expo}, {8'h0, want.expo});
      compare("line_end", {15'h0, got.last}, {15'h0, want.last});
      compare("overrun", {15'h0, got.clip}, {15'h0, want.clip});
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] start_column;
  logic [15:0] run_count;
  logic [2:0]  target;
  logic [7:0]  red_value;
  logic [7:0]  green_value;
  logic [7:0]  blue_value;
  logic [7:0]  exponent_value;
  logic        line_end;
  logic        overrun;

  descriptor_scoreboard sb = new();
  descriptor_t seen_run;
  logic [7:0] stream_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  rgbe_scanline_rle_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .start_column(start_column),
    .run_count(run_count),
    .target(target),
    .red_value(red_value),
    .green_value(green_value),
    .blue_value(blue_value),
    .exponent_value(exponent_value),
    .line_end(line_end),
    .overrun(overrun)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  assign seen_run = {start_column, run_count, target, red_value, green_value,
                     blue_value, exponent_value, line_end, overrun};

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_descriptor(seen_run);
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task send_byte(input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = d;
    do @(posedge clk); while (in_stall);
    sb.note_byte(d);
    @(negedge clk);
  endtask

  task write_width(input logic [15:0] v);
    in_valid = 1'b0;
    while (sb.expected_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_width(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task set_mode(input int m);
    case (m)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 65; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 65; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  function automatic bit old_pixels(int unsigned w, int unsigned col, bit at_start,
                                    int unsigned cap);
    int unsigned shift;
    longint unsigned want;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] c;
    int unsigned pick;
    shift = 0;
    while (col < w) begin
      if (stream_q.size() > cap) return 1'b0;
      if ($urandom_range(99) < 35) begin
        pick = $urandom_range(9);
        if (pick == 0) c = 8'd0;
        else if (pick < 5) c = 8'($urandom_range(1, 4));
        else c = 8'($urandom_range(1, 255));
        stream_q.push_back(8'd1);
        stream_q.push_back(8'd1);
        stream_q.push_back(8'd1);
        stream_q.push_back(c);
        want = c;
        want = want << shift;
        shift = (shift >= 24) ? 24 : shift + 8;
        if (want > w - col) col = w;
        else col += 32'(want);
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (at_start && r == HDR_BYTE) r = 8'd3;
        if (r == 8'd1 && g == 8'd1 && b == 8'd1) b = 8'd0;
        stream_q.push_back(r);
        stream_q.push_back(g);
        stream_q.push_back(b);
        stream_q.push_back(8'($urandom));
        col++;
        shift = 0;
      end
      at_start = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit new_line(int unsigned w, int unsigned cap);
    int unsigned col;
    int unsigned rem;
    int unsigned len;
    int unsigned kind;
    int unsigned fit;
    stream_q.push_back(HDR_BYTE);
    stream_q.push_back(HDR_BYTE);
    stream_q.push_back(8'($urandom_range(127)));
    stream_q.push_back(8'($urandom));
    for (int p = 0; p < 4; p++) begin
      col = 0;
      while (col < w) begin
        if (stream_q.size() > cap) return 1'b0;
        rem = w - col;
        kind = $urandom_range(99);
        if (kind < 5) begin
          stream_q.push_back(8'd0);
        end else if (kind < 50) begin
          if (rem < 127 && $urandom_range(9) == 0) len = $urandom_range(rem + 1, 127);
          else len = $urandom_range(1, (rem < 127) ? rem : 127);
          stream_q.push_back(8'(128 + len));
          stream_q.push_back(8'($urandom));
          col += (len < rem) ? len : rem;
        end else begin
          if (rem < 128 && $urandom_range(9) == 0) len = $urandom_range(rem + 1, 128);
          else if ($urandom_range(4) != 0) len = $urandom_range(1, (rem < 16) ? rem : 16);
          else len = $urandom_range(1, (rem < 128) ? rem : 128);
          fit = (len < rem) ? len : rem;
          stream_q.push_back(8'(len));
          repeat (fit) stream_q.push_back(8'($urandom));
          col += fit;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic bit broken_header_line(int unsigned w, int unsigned cap);
    logic [7:0] g;
    logic [7:0] b;
    g = 8'($urandom);
    b = 8'($urandom);
    if ($urandom_range(1) == 0) begin
      if (g == HDR_BYTE) g = 8'd3;
    end else begin
      g = HDR_BYTE;
      b[7] = 1'b1;
    end
    stream_q.push_back(HDR_BYTE);
    stream_q.push_back(g);
    stream_q.push_back(b);
    stream_q.push_back(8'($urandom));
    return old_pixels(w, 1, 1'b0, cap);
  endfunction

  task run_phase(input logic [15:0] width, input int unsigned budget);
    int unsigned w;
    int unsigned sent;
    int unsigned kind;
    bit whole;
    w = (width == 16'd0) ? 1 : width;
    sent = 0;
    whole = 1'b1;
    while (sent < budget && whole) begin
      stream_q.delete();
      kind = $urandom_range(99);
      if (w >= MIN_NEW_WIDTH && w <= MAX_NEW_WIDTH && kind < 70) whole = new_line(w, 120);
      else if (kind < 85) whole = old_pixels(w, 0, 1'b1, 120);
      else whole = broken_header_line(w, 120);
      foreach (stream_q[i]) send_byte(stream_q[i]);
      sent += stream_q.size();
    end
    if ($urandom_range(1) == 0) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
  endtask

  initial begin
    logic [7:0] opening[$];
    logic [15:0] widths[$];
    opening = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd200};
    widths = '{16'd8, 16'd12, 16'd20, 16'd33, 16'd1, 16'd64, 16'd9, 16'd7, 16'd16,
               16'd65535, 16'd32767, 16'd32768, 16'd0, 16'd128, 16'd8, 16'd40,
               16'd3, 16'd24};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_mode(0);
    foreach (opening[i]) send_byte(opening[i]);
    write_width(16'd8);
    opening = '{HDR_BYTE, HDR_BYTE, 8'd128, 8'd0, HDR_BYTE, 8'd5, 8'd0, 8'd0};
    foreach (opening[i]) send_byte(opening[i]);
    foreach (widths[i]) begin
      write_width(widths[i]);
      set_mode(i % 4);
      run_phase(widths[i], 95);
    end
    in_valid = 1'b0;
    while (sb.expected_runs.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_runs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rgbe_pkg.sv
hw/rtl/rgbe_front.sv
hw/rtl/rgbe_back.sv
hw/rtl/rgbe_scanline_rle_decoder.sv
tb/rgbe_scanline_rle_decoder_test.sv
